### design/pidis_pkg.sv
// ----------------------------------------------------------------------------
// pidis_pkg: shared types and constants for the PID integral separation block
// Configuration record, multiplier request, register indexes and the reset
// values of the configuration registers.
// ----------------------------------------------------------------------------
package pidis_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SUM_WIDTH_DEF = 48;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register indexes; register i sits at byte address 4*i.
  localparam int REG_IDX_W = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SETPOINT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_MODE     = REG_IDX_W'(4);

  // Shared multiplier: a zero-extended 16-bit gain times a 34-bit signed operand.
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 34;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [31:0] SETPOINT_RST = 32'sd2293760;
  localparam logic [15:0]        GAIN_P_RST   = 16'd6554;
  localparam logic [15:0]        GAIN_I_RST   = 16'd1638;
  localparam logic [15:0]        GAIN_D_RST   = 16'd6554;
  localparam logic               MODE_RST     = 1'b0;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic               separation_mode;
  } cfg_t;

  typedef struct packed {
    logic                       en;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } mul_req_t;

endpackage

### design/pidis_mul.sv
// ----------------------------------------------------------------------------
// pidis_mul: shared signed multiplier with registered product
// One product per cycle; the product register loads only when requested.
// ----------------------------------------------------------------------------
module pidis_mul (
  input  logic                                   clk_i,
  input  pidis_pkg::mul_req_t                    req_i,
  output logic signed [pidis_pkg::MUL_P_W-1:0]   p_o
);

  logic signed [pidis_pkg::MUL_A_W-1:0] op_a;
  logic signed [pidis_pkg::MUL_B_W-1:0] op_b;
  logic signed [pidis_pkg::MUL_P_W-1:0] p_d;
  logic signed [pidis_pkg::MUL_P_W-1:0] p_q;

  assign op_a = req_i.a;
  assign op_b = req_i.b;
  assign p_d  = pidis_pkg::MUL_P_W'(op_a) * pidis_pkg::MUL_P_W'(op_b);

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

### design/pidis_cfg.sv
// ----------------------------------------------------------------------------
// pidis_cfg: APB register file for setpoint, gains and separation mode
// Writes land at the access phase; reads return the register value.
// ----------------------------------------------------------------------------
module pidis_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidis_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pidis_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pidis_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output pidis_pkg::cfg_t                     cfg_o
);

  localparam int IDX_W = pidis_pkg::REG_IDX_W;

  pidis_pkg::cfg_t  cfg_q;
  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[pidis_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint        <= pidis_pkg::SETPOINT_RST;
      cfg_q.gain_p          <= pidis_pkg::GAIN_P_RST;
      cfg_q.gain_i          <= pidis_pkg::GAIN_I_RST;
      cfg_q.gain_d          <= pidis_pkg::GAIN_D_RST;
      cfg_q.separation_mode <= pidis_pkg::MODE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        pidis_pkg::REG_SETPOINT: cfg_q.setpoint        <= pwdata[31:0];
        pidis_pkg::REG_GAIN_P:   cfg_q.gain_p          <= pwdata[15:0];
        pidis_pkg::REG_GAIN_I:   cfg_q.gain_i          <= pwdata[15:0];
        pidis_pkg::REG_GAIN_D:   cfg_q.gain_d          <= pwdata[15:0];
        pidis_pkg::REG_MODE:     cfg_q.separation_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pidis_pkg::REG_SETPOINT:
        prdata = pidis_pkg::APB_DATA_W'(unsigned'(cfg_q.setpoint));
      pidis_pkg::REG_GAIN_P: prdata = pidis_pkg::APB_DATA_W'(cfg_q.gain_p);
      pidis_pkg::REG_GAIN_I: prdata = pidis_pkg::APB_DATA_W'(cfg_q.gain_i);
      pidis_pkg::REG_GAIN_D: prdata = pidis_pkg::APB_DATA_W'(cfg_q.gain_d);
      pidis_pkg::REG_MODE:   prdata = pidis_pkg::APB_DATA_W'(cfg_q.separation_mode);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### design/pidis_core.sv
// ----------------------------------------------------------------------------
// pidis_core: sequencer and accumulator of the PID step
// Steps one item through error, integral, gain products and rounding,
// sharing a single multiplier.
// ----------------------------------------------------------------------------
module pidis_core #(
  parameter int FRAC_BITS = pidis_pkg::FRAC_BITS_DEF,
  parameter int SUM_WIDTH = pidis_pkg::SUM_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pidis_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  measured_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  drive_o
);

  localparam int K_W    = 32 - FRAC_BITS;
  localparam int ACC_W  = 64;
  localparam int TERM_W = (SUM_WIDTH + 16 > 61) ? SUM_WIDTH + 16 : 61;

  localparam logic [15:0] BETA_030 = 16'd9830;
  localparam logic [15:0] BETA_060 = 16'd19661;
  localparam logic [15:0] BETA_090 = 16'd29491;
  localparam logic [15:0] BETA_ONE = 16'd32768;

  localparam logic [K_W-1:0] BAND_10 = K_W'(10);
  localparam logic [K_W-1:0] BAND_20 = K_W'(20);
  localparam logic [K_W-1:0] BAND_30 = K_W'(30);
  localparam logic [K_W-1:0] BAND_40 = K_W'(40);

  localparam logic [TERM_W-1:0]       TERM_LIMIT = TERM_W'(1) << 60;
  localparam logic [31:0]             BK_HALF    = 32'd16384;
  localparam logic signed [ACC_W-1:0] DRIVE_HALF = 64'sd16384;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_BK,
    S_PROP,
    S_DERIV,
    S_INT_LO,
    S_INT_HI,
    S_INT_ADD,
    S_OUT
  } state_e;

  state_e                       state_q;
  logic                         out_valid_q;
  logic signed [31:0]           drive_q;
  logic signed [31:0]           prev_q;
  logic signed [SUM_WIDTH-1:0]  sum_q;

  logic signed [31:0]           e_q;
  logic signed [32:0]           de_q;
  logic [15:0]                  bk_q;
  logic [SUM_WIDTH-1:0]         mag_q;
  logic                         neg_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic [TERM_W-1:0]            term_q;

  logic signed [32:0]           err_diff;
  logic signed [31:0]           err_sat;
  logic [31:0]                  err_mag;
  logic [K_W-1:0]               band_k;
  logic [15:0]                  beta;
  logic signed [SUM_WIDTH:0]    sum_wide;
  logic signed [SUM_WIDTH-1:0]  sum_sat;
  logic [SUM_WIDTH-1:0]         sum_mag;
  logic signed [32:0]           de_diff;
  logic [31:0]                  bk_sum;
  logic [60:0]                  term_clamp;
  logic signed [ACC_W-1:0]      term_ext;
  logic signed [ACC_W-1:0]      round_sum;
  logic signed [ACC_W-1:0]      round_shr;
  logic signed [31:0]           drive_sat;
  logic signed [ACC_W-1:0]      prod_ext;
  logic                         out_load;

  pidis_pkg::mul_req_t                    mul_req;
  logic signed [pidis_pkg::MUL_P_W-1:0]   prod;

  pidis_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .p_o   (prod)
  );

  // Error, saturated to 32 bits.
  assign err_diff = 33'(cfg_i.setpoint) - 33'(measured_i);
  always_comb begin
    if (err_diff[32] != err_diff[31]) begin
      err_sat = err_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err_sat = err_diff[31:0];
    end
  end

  // Band selection on the integer part of |e|; first match wins.
  assign err_mag = e_q[31] ? (~e_q + 32'd1) : e_q;
  assign band_k  = err_mag[31:FRAC_BITS];
  always_comb begin
    if (!cfg_i.separation_mode) begin
      beta = BETA_ONE;
    end else if (band_k >= BAND_30 && band_k <= BAND_40) begin
      beta = BETA_030;
    end else if (band_k >= BAND_20 && band_k <= BAND_30) begin
      beta = BETA_060;
    end else if (band_k >= BAND_10 && band_k <= BAND_20) begin
      beta = BETA_090;
    end else begin
      beta = BETA_ONE;
    end
  end

  // Saturating integral update.
  assign sum_wide = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(e_q);
  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  assign sum_mag  = sum_q[SUM_WIDTH-1] ? (~sum_q + SUM_WIDTH'(1)) : sum_q;
  assign de_diff  = 33'(e_q) - 33'(prev_q);
  assign bk_sum   = prod[31:0] + BK_HALF;
  assign prod_ext = ACC_W'(prod);

  // Integral term magnitude limited to 2^60.
  assign term_clamp = (term_q > TERM_LIMIT) ? TERM_LIMIT[60:0] : term_q[60:0];
  assign term_ext   = signed'({3'b000, term_clamp});

  // Round half up at Q15, then saturate to 32 bits.
  assign round_sum = acc_q + DRIVE_HALF;
  assign round_shr = round_sum >>> 15;
  always_comb begin
    if (round_shr[ACC_W-1:31] == '0 || round_shr[ACC_W-1:31] == '1) begin
      drive_sat = round_shr[31:0];
    end else begin
      drive_sat = round_shr[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      S_SUM: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, cfg_i.gain_i};
        mul_req.b  = pidis_pkg::MUL_B_W'(beta);
      end
      S_BK: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, cfg_i.gain_p};
        mul_req.b  = pidis_pkg::MUL_B_W'(e_q);
      end
      S_PROP: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, cfg_i.gain_d};
        mul_req.b  = pidis_pkg::MUL_B_W'(de_q);
      end
      S_DERIV: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, bk_q};
        mul_req.b  = pidis_pkg::MUL_B_W'(32'(mag_q));
      end
      S_INT_LO: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, bk_q};
        mul_req.b  = pidis_pkg::MUL_B_W'(32'(mag_q >> 32));
      end
      default: ;
    endcase
  end

  assign out_load = !out_valid_q || out_ready_i;

  // Control, architectural state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
    end else begin
      // The final step sets the valid flag itself when it reloads the register.
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          prev_q  <= e_q;
          sum_q   <= sum_sat;
          state_q <= S_BK;
        end
        S_BK:      state_q <= S_PROP;
        S_PROP:    state_q <= S_DERIV;
        S_DERIV:   state_q <= S_INT_LO;
        S_INT_LO:  state_q <= S_INT_HI;
        S_INT_HI:  state_q <= S_INT_ADD;
        S_INT_ADD: state_q <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            drive_q     <= drive_sat;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          e_q <= err_sat;
        end
      end
      S_SUM: de_q <= de_diff;
      S_BK: begin
        bk_q  <= bk_sum[30:15];
        mag_q <= sum_mag;
        neg_q <= sum_q[SUM_WIDTH-1];
      end
      S_PROP:    acc_q  <= prod_ext;
      S_DERIV:   acc_q  <= acc_q + prod_ext;
      S_INT_LO:  term_q <= TERM_W'(prod[47:0]);
      S_INT_HI:  term_q <= term_q + (TERM_W'(prod[47:0]) << 32);
      S_INT_ADD: acc_q  <= neg_q ? (acc_q - term_ext) : (acc_q + term_ext);
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

### design/pid_integral_separation.sv
// ----------------------------------------------------------------------------
// pid_integral_separation: positional PID step with integral separation
// Signed Q16.16 controller; one drive value for each measured value.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the input channel (in_valid_i/in_ready_o, measured_i) is one
// measured process value. The block forms the error against the setpoint,
// adds it to a saturating integral, and returns one drive item on the output
// channel (out_valid_o/out_ready_i, drive_o).
// A single 17x34-bit multiplier forms, one after another, the integral weight,
// the proportional and derivative products and the two halves of the integral
// product, so the block takes no new item until the current one's result is
// registered; the next item is accepted once the sequencer is back in idle.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the following item finishes its arithmetic
// and then holds in its last step until the output register is free.
// pready is always high. Reset clears the previous error and the integral and
// loads the register defaults (setpoint 35.0, gains 0.2, 0.05, 0.2, banding
// off). Write the APB port only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module pid_integral_separation #(
  parameter int FRAC_BITS = pidis_pkg::FRAC_BITS_DEF,
  parameter int SUM_WIDTH = pidis_pkg::SUM_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pidis_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pidis_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pidis_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [31:0]                 measured_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [31:0]                 drive_o
);

  pidis_pkg::cfg_t cfg;

  // Configuration registers.
  pidis_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer, shared multiplier and output register.
  pidis_core #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

  // Once an item is taken, the block stays busy through its whole sequence.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after an item was taken");

  a_busy_full_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##8 !in_ready_o)
    else $error("item sequence ended before its last step");

  // A new result only appears as the sequencer returns to idle.
  a_result_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result appeared outside the final step");

  // After a result is taken, valid stays high only if a new result was loaded.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o || in_ready_o)
    else $error("result held after it was taken");

endmodule

### tb/tb_pid_integral_separation.sv
// ----------------------------------------------------------------------------
// tb_pid_integral_separation: self-checking bench for the PID step block
// A queue-fed driver offers measured values, and a monitor predicts each drive
// value from its own copy of the controller state and compares it with the
// block's result. Directed corner cases come first. Random items follow under
// several register settings and idling patterns. A short integral wind-up
// burst and the descent from it come last.
// ----------------------------------------------------------------------------
module tb_pid_integral_separation;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map: one 32-bit word per register.
  localparam logic [pidis_pkg::APB_ADDR_W-1:0] ADDR_SETPOINT = {pidis_pkg::REG_SETPOINT, 2'b00};
  localparam logic [pidis_pkg::APB_ADDR_W-1:0] ADDR_GAIN_P   = {pidis_pkg::REG_GAIN_P, 2'b00};
  localparam logic [pidis_pkg::APB_ADDR_W-1:0] ADDR_GAIN_I   = {pidis_pkg::REG_GAIN_I, 2'b00};
  localparam logic [pidis_pkg::APB_ADDR_W-1:0] ADDR_GAIN_D   = {pidis_pkg::REG_GAIN_D, 2'b00};
  localparam logic [pidis_pkg::APB_ADDR_W-1:0] ADDR_MODE     = {pidis_pkg::REG_MODE, 2'b00};
  // First word past the register list; writes to it must change nothing.
  localparam logic [pidis_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = 5'd20;

  localparam int FRAC = pidis_pkg::FRAC_BITS_DEF;

  // Integral weights in Q1.15.
  localparam longint BETA_030 = 9830;
  localparam longint BETA_060 = 19661;
  localparam longint BETA_090 = 29491;
  localparam longint BETA_ONE = 32768;

  localparam longint Q31_MAX    = 64'sd2147483647;
  localparam longint Q31_MIN    = -64'sd2147483648;
  localparam longint SUM_MAX    = (longint'(1) <<< (pidis_pkg::SUM_WIDTH_DEF - 1)) - 1;
  localparam longint SUM_MIN    = -SUM_MAX - 1;
  localparam longint TERM_CLAMP = longint'(1) <<< 60;

  localparam int SEGMENT_ITEMS = 284;
  localparam int WINDUP_ITEMS  = 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [pidis_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [pidis_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [pidis_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;

  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] measured_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] drive_o;

  pid_integral_separation u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the registers and of the controller state.
  pidis_pkg::cfg_t shadow_cfg = '{setpoint: pidis_pkg::SETPOINT_RST,
                                  gain_p: pidis_pkg::GAIN_P_RST,
                                  gain_i: pidis_pkg::GAIN_I_RST,
                                  gain_d: pidis_pkg::GAIN_D_RST,
                                  separation_mode: pidis_pkg::MODE_RST};
  longint last_err = 0;
  longint err_integral = 0;

  logic signed [31:0] pending_meas[$];
  logic signed [31:0] drive_expected[$];

  int meas_queued = 0;
  int meas_taken_cnt = 0;
  int fail_cnt = 0;
  logic in_fire = 1'b0;

  // Idling controls, in percent of cycles.
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  logic sink_hold = 1'b0;
  logic hold_arm = 1'b0;

  // Computes the drive value for one measured value and advances the state:
  // saturated error, saturating integral, banded integral weight, and the
  // rounded, saturated sum of the three terms.
  function automatic logic signed [31:0] predict_drive(input logic signed [31:0] meas);
    longint sp, kp, ki, kd, e, de, mag, k, beta, bk, term, total;
    sp = $signed(shadow_cfg.setpoint);
    kp = shadow_cfg.gain_p;
    ki = shadow_cfg.gain_i;
    kd = shadow_cfg.gain_d;

    e = sp - longint'(meas);
    if (e > Q31_MAX) e = Q31_MAX;
    else if (e < Q31_MIN) e = Q31_MIN;
    de = e - last_err;

    if (e > 0 && err_integral > SUM_MAX - e) err_integral = SUM_MAX;
    else if (e < 0 && err_integral < SUM_MIN - e) err_integral = SUM_MIN;
    else err_integral = err_integral + e;

    // The first matching band wins, so 20 and 30 fall into the upper band.
    beta = BETA_ONE;
    if (shadow_cfg.separation_mode) begin
      mag = (e < 0) ? -e : e;
      k = mag >>> FRAC;
      if (k >= 30 && k <= 40) beta = BETA_030;
      else if (k >= 20 && k <= 30) beta = BETA_060;
      else if (k >= 10 && k <= 20) beta = BETA_090;
    end
    bk = (beta * ki + 16384) >>> 15;

    // The magnitude product stays below 2^63; it is clamped at 2^60.
    mag = (err_integral < 0) ? -err_integral : err_integral;
    term = bk * mag;
    if (term > TERM_CLAMP) term = TERM_CLAMP;
    if (err_integral < 0) term = -term;

    total = (kp * e + kd * de + term + 16384) >>> 15;
    if (total > Q31_MAX) total = Q31_MAX;
    else if (total < Q31_MIN) total = Q31_MIN;

    last_err = e;
    return total[31:0];
  endfunction

  // Draws a measured value, mostly close to the setpoint so the error lands
  // in or near the integral bands, with some raw and extreme values mixed in.
  function automatic logic signed [31:0] pick_measured();
    int sel, k, frac, err;
    sel = $urandom_range(99);
    if (sel < 55) begin
      err = $urandom_range(100 << 16);
      err = err - (50 << 16);
    end else if (sel < 75) begin
      // Integer part on either side of a band boundary.
      k = 10 * $urandom_range(1, 4) + $urandom_range(2) - 1;
      case ($urandom_range(2))
        0: frac = 0;
        1: frac = 16'hFFFF;
        default: frac = $urandom_range(16'hFFFF);
      endcase
      err = (k << 16) | frac;
      if ($urandom_range(1)) err = -err;
    end else if (sel < 90) begin
      return $urandom();
    end else begin
      case ($urandom_range(4))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return '0;
        3: return shadow_cfg.setpoint;
        default: return shadow_cfg.setpoint + 1;
      endcase
    end
    return shadow_cfg.setpoint - err;
  endfunction

  task automatic queue_meas(input logic signed [31:0] meas);
    pending_meas.push_back(meas);
    meas_queued++;
  endtask

  // One APB write: setup cycle, access cycle, register written at the edge
  // that ends the access cycle.
  task automatic reg_write(input logic [pidis_pkg::APB_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_SETPOINT: shadow_cfg.setpoint = data;
      ADDR_GAIN_P:   shadow_cfg.gain_p = data[15:0];
      ADDR_GAIN_I:   shadow_cfg.gain_i = data[15:0];
      ADDR_GAIN_D:   shadow_cfg.gain_d = data[15:0];
      ADDR_MODE:     shadow_cfg.separation_mode = data[0];
      default: ;
    endcase
  endtask

  // Loads a full register setting; the bits above each register's width carry
  // random junk, which the block must ignore.
  task automatic load_setting(input logic [31:0] sp, input logic [15:0] kp,
                              input logic [15:0] ki, input logic [15:0] kd,
                              input logic mode);
    reg_write(ADDR_SETPOINT, sp);
    reg_write(ADDR_GAIN_P, {16'($urandom()), kp});
    reg_write(ADDR_GAIN_I, {16'($urandom()), ki});
    reg_write(ADDR_GAIN_D, {16'($urandom()), kd});
    reg_write(ADDR_MODE, {31'($urandom()), mode});
  endtask

  // Waits until every queued item has been taken and every drive value has
  // come back, then lets the block settle before registers change.
  task automatic wait_idle();
    while (meas_taken_cnt != meas_queued || drive_expected.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // Sender: keeps an item on the bus until it is taken, then either loads the
  // next one or lets the bus idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (pending_meas.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        measured_i <= pending_meas.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus the long hold-off below.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: results are checked before the new expectation of the same edge
  // is queued, so a result can never be matched against its own item.
  always @(posedge clk_i) begin : monitor
    logic signed [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (drive_expected.size() == 0) begin
          $error("drive: unexpected result %0d", drive_o);
          fail_cnt++;
        end else begin
          want = drive_expected.pop_front();
          if (drive_o !== want) begin
            $error("drive: expected %0d, actual %0d", want, drive_o);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        drive_expected.push_back(predict_drive(measured_i));
        meas_taken_cnt++;
      end
    end
    in_fire <= rst_ni && in_valid_i && in_ready_o;
  end

  // Long receiver hold-off early in the first random segment, while the
  // sender still has plenty of items to offer; the block must stall its input.
  initial begin
    wait (hold_arm);
    repeat (300) @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (500) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  initial begin
    #(64'd60_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: zero error, a plain error, and both measurement
    // extremes, the lower one overflowing the error.
    queue_meas(32'sd2293760);
    queue_meas('0);
    queue_meas(32'sh7FFF_FFFF);
    queue_meas(32'sh8000_0000);
    wait_idle();

    // Banded mode with a zero setpoint, so the error is minus the measurement.
    // Band boundaries on both sides, with whole and fractional parts. A write
    // past the register list comes first and must leave everything alone.
    reg_write(ADDR_UNMAPPED, $urandom());
    load_setting('0, pidis_pkg::GAIN_P_RST, pidis_pkg::GAIN_I_RST,
                 pidis_pkg::GAIN_D_RST, 1'b1);
    queue_meas(-((9 << 16) | 16'hFFFF));
    queue_meas(-(10 << 16));
    queue_meas(-((20 << 16) | 16'hFFFF));
    queue_meas(-(20 << 16));
    queue_meas(-(30 << 16));
    queue_meas(-((40 << 16) | 16'hFFFF));
    queue_meas(-(41 << 16));
    queue_meas(30 << 16);
    queue_meas((40 << 16) | 16'hFFFF);
    queue_meas((25 << 16) | 16'h8000);
    queue_meas('0);
    wait_idle();

    // Random segments, each with its own setting and idling pattern.
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: load_setting(32'sd2293760, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        1: load_setting($urandom(), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 1'b0);
        2: load_setting(32'h8000_0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        3: load_setting(32'h7FFF_FFFF, 16'hFFFF, 16'h0000, 16'h0001, 1'b1);
        4: load_setting($urandom(), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 1'b1);
        default: load_setting(pidis_pkg::SETPOINT_RST, pidis_pkg::GAIN_P_RST,
                              pidis_pkg::GAIN_I_RST, pidis_pkg::GAIN_D_RST, 1'b1);
      endcase
      if (seg < 2) begin
        src_idle_pct = 12;
        sink_idle_pct = 64;
      end else if (seg < 4) begin
        src_idle_pct = 64;
        sink_idle_pct = 12;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      for (int n = 0; n < SEGMENT_ITEMS; n++) queue_meas(pick_measured());
      if (seg == 0) hold_arm = 1'b1;
      wait_idle();
    end

    // Wind-up: the largest error every step, with the integral gain at its
    // maximum, grows the integral term quickly from item to item.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    load_setting(32'h7FFF_FFFF, pidis_pkg::GAIN_P_RST, 16'hFFFF,
                 pidis_pkg::GAIN_D_RST, 1'b0);
    for (int n = 0; n < WINDUP_ITEMS; n++) queue_meas(32'sh8000_0000);
    wait_idle();

    // Come back down from the wound-up integral with the weight switched off,
    // so the proportional and derivative terms show alone.
    load_setting(32'h8000_0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    for (int n = 0; n < 8; n++) queue_meas(32'sh7FFF_FFFF);
    queue_meas('0);
    wait_idle();

    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0 && drive_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
